FILE: hw/rtl/gea_pkg.sv
package gea_pkg;

	localparam int MAX_RANK    = 8;
	localparam int SIZE_BITS   = 16;
	localparam int OFFSET_BITS = 32;
	localparam int INDEX_BITS  = 32;
	localparam int RANK_W      = 4;
	localparam int AXIS_W      = 3;
	localparam int DIM_W       = $clog2(MAX_RANK);
	localparam int FIELD_W     = 16;
	localparam int CFG_DATA_W  = 64;
	localparam int CFG_INDEX_W = 3;

	// register indexes of the configuration port
	localparam logic [CFG_INDEX_W-1:0] REG_RANK         = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_GATHER_AXIS  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_DIM_SIZES_LO = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_DIM_SIZES_HI = 3'd3;

	localparam logic [RANK_W-1:0]     RANK_RESET  = 4'd1;
	localparam logic [AXIS_W-1:0]     AXIS_RESET  = 3'd0;
	localparam logic [CFG_DATA_W-1:0] SIZES_RESET = 64'h0001_0001_0001_0001;

	typedef logic [SIZE_BITS-1:0]   size_t;
	typedef logic [OFFSET_BITS-1:0] offset_t;
	typedef logic [DIM_W-1:0]       dim_t;

	// controller to datapath
	typedef struct packed {
		logic init;
		logic stride_step;
		logic accept;
		logic mac_step;
		logic load;
	} gea_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic stride_done;
		logic mac_last;
	} gea_status_t;

	// rank of 0 acts as 1, rank above the maximum acts as the maximum
	function automatic logic [RANK_W-1:0] eff_rank(input logic [RANK_W-1:0] r);
		logic [RANK_W-1:0] res;
		if (r == '0)
			res = RANK_W'(1);
		else if (r > RANK_W'(MAX_RANK))
			res = RANK_W'(MAX_RANK);
		else
			res = r;
		return res;
	endfunction

endpackage

FILE: hw/rtl/gea_in_if.sv
interface gea_in_if;
	import gea_pkg::*;

	logic                         valid;
	logic                         ready;
	logic signed [INDEX_BITS-1:0] gather_index;

	modport source (output valid, output gather_index, input ready);
	modport sink (input valid, input gather_index, output ready);
endinterface

FILE: hw/rtl/gea_out_if.sv
interface gea_out_if;
	import gea_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [OFFSET_BITS-1:0] source_offset;
	logic [OFFSET_BITS-1:0] dest_offset;
	logic                   last_element;

	modport source (output valid, output source_offset, output dest_offset,
		output last_element, input ready);
	modport sink (input valid, input source_offset, input dest_offset,
		input last_element, output ready);
endinterface

FILE: hw/rtl/gea_ctrl.sv
module gea_ctrl
	import gea_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        in_valid,
	input  logic        out_ready,
	input  gea_status_t status,
	output gea_cmd_t    cmd,
	output logic        in_ready,
	output logic        out_valid
);

	typedef enum logic [2:0] {
		ST_INIT,
		ST_STRIDE,
		ST_IDLE,
		ST_MAC,
		ST_FINAL
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);

	always_comb begin
		cmd             = '0;
		cmd.init        = (state_q == ST_INIT);
		cmd.stride_step = (state_q == ST_STRIDE) && !status.stride_done;
		cmd.accept      = in_ready && in_valid;
		cmd.mac_step    = (state_q == ST_MAC);
		cmd.load        = (state_q == ST_FINAL) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			if (cfg_we) begin
				state_q <= ST_INIT;
			end else begin
				unique case (state_q)
					ST_INIT: state_q <= ST_STRIDE;
					ST_STRIDE: begin
						if (status.stride_done)
							state_q <= ST_IDLE;
					end
					ST_IDLE: begin
						if (in_valid)
							state_q <= ST_MAC;
					end
					ST_MAC: begin
						if (status.mac_last)
							state_q <= ST_FINAL;
					end
					ST_FINAL: begin
						if (slot_free)
							state_q <= ST_IDLE;
					end
					default: state_q <= ST_INIT;
				endcase
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: hw/rtl/gea_datapath.sv
module gea_datapath
	import gea_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [CFG_INDEX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_wdata,
	input  gea_cmd_t                     cmd,
	input  logic signed [INDEX_BITS-1:0] gather_index,
	output gea_status_t                  status,
	output offset_t                      source_offset,
	output offset_t                      dest_offset,
	output logic                         last_element
);

	logic [RANK_W-1:0]     rank_q;
	logic [AXIS_W-1:0]     axis_q;
	logic [CFG_DATA_W-1:0] sizes_lo_q;
	logic [CFG_DATA_W-1:0] sizes_hi_q;

	size_t   coord_q  [MAX_RANK];
	offset_t stride_q [MAX_RANK];
	offset_t elem_q;
	offset_t run_q;
	dim_t    sj_q;
	dim_t    mj_q;
	offset_t idx_q;
	offset_t prod_s1;
	offset_t acc_q;
	offset_t src_q;
	offset_t dst_q;
	logic    last_q;

	size_t   size_w   [MAX_RANK];
	logic    wrap_w   [MAX_RANK];
	size_t   coord_nx [MAX_RANK];
	logic    last_w;
	dim_t    r_last;
	offset_t stride_next;
	offset_t mac_opnd;
	offset_t mac_prod;

	assign r_last = DIM_W'(eff_rank(rank_q) - 1'b1);

	// size fields, zero acts as one
	for (genvar j = 0; j < MAX_RANK; j++) begin : g_size
		logic [FIELD_W-1:0] field;
		assign field = (j < 4) ? sizes_lo_q[(j % 4) * FIELD_W +: FIELD_W]
			: sizes_hi_q[(j % 4) * FIELD_W +: FIELD_W];
		assign size_w[j] = (field[SIZE_BITS-1:0] == '0) ? SIZE_BITS'(1)
			: field[SIZE_BITS-1:0];
		assign wrap_w[j] = (coord_q[j] == SIZE_BITS'(size_w[j] - 1'b1));
	end

	// odometer step, lowest-order digit is the highest dimension
	always_comb begin
		logic carry;
		carry = 1'b1;
		for (int d = MAX_RANK - 1; d >= 0; d--) begin
			if (DIM_W'(d) <= r_last) begin
				coord_nx[d] = carry ? (wrap_w[d] ? '0 : SIZE_BITS'(coord_q[d] + 1'b1))
					: coord_q[d];
				carry = carry & wrap_w[d];
			end else begin
				coord_nx[d] = coord_q[d];
			end
		end
		last_w = carry;
	end

	assign stride_next = OFFSET_BITS'(run_q * OFFSET_BITS'(size_w[sj_q]));
	assign mac_opnd    = (mj_q == axis_q) ? idx_q : OFFSET_BITS'(coord_q[mj_q]);
	assign mac_prod    = OFFSET_BITS'(mac_opnd * stride_q[mj_q]);

	assign status.stride_done = (sj_q == '0);
	assign status.mac_last    = (mj_q == r_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q     <= RANK_RESET;
			axis_q     <= AXIS_RESET;
			sizes_lo_q <= SIZES_RESET;
			sizes_hi_q <= SIZES_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RANK:         rank_q     <= cfg_wdata[RANK_W-1:0];
				REG_GATHER_AXIS:  axis_q     <= cfg_wdata[AXIS_W-1:0];
				REG_DIM_SIZES_LO: sizes_lo_q <= cfg_wdata;
				REG_DIM_SIZES_HI: sizes_hi_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.init) begin
			for (int j = 0; j < MAX_RANK; j++) begin
				coord_q[j]  <= '0;
				stride_q[j] <= (DIM_W'(j) == r_last) ? OFFSET_BITS'(1) : '0;
			end
			run_q            <= OFFSET_BITS'(1);
			sj_q             <= r_last;
			elem_q           <= '0;
		end
		if (cmd.stride_step) begin
			stride_q[sj_q - 1'b1] <= stride_next;
			run_q                 <= stride_next;
			sj_q                  <= sj_q - 1'b1;
		end
		if (cmd.accept) begin
			idx_q   <= OFFSET_BITS'(gather_index);
			mj_q    <= '0;
			prod_s1 <= '0;
			acc_q   <= '0;
		end
		if (cmd.mac_step) begin
			prod_s1 <= mac_prod;
			acc_q   <= acc_q + prod_s1;
			mj_q    <= mj_q + 1'b1;
		end
		if (cmd.load) begin
			src_q  <= acc_q + prod_s1;
			dst_q  <= elem_q;
			last_q <= last_w;
			for (int j = 0; j < MAX_RANK; j++)
				coord_q[j] <= coord_nx[j];
			elem_q <= last_w ? '0 : elem_q + 1'b1;
		end
	end

	assign source_offset = src_q;
	assign dest_offset   = dst_q;
	assign last_element  = last_q;

endmodule

FILE: hw/rtl/gather_elements_address_gen.sv
// Gather-elements address generator: takes one gather index per output element in
// row-major order and returns the source element offset, the destination offset and
// a flag on the tensor's final element. Each item runs from its accept cycle through
// one step per dimension on the single shared 32x32 multiply-accumulate to the
// final add into the output register, which waits for a free output slot;
// the next item is accepted while a result still waits on the output side. After
// reset and after every write to a known configuration register the stride table is
// rebuilt with one multiply per cycle, which keeps the input side stalled until the
// table is complete; the odometer and destination counter restart at zero. Writes to
// an unknown register index are ignored. Offsets wrap modulo 2^32 and indices are
// not range-checked.
module gather_elements_address_gen
	import gea_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	gea_in_if.sink                 in_stream,
	gea_out_if.source              out_stream
);

	gea_cmd_t    cmd;
	gea_status_t status;
	logic        in_ready;
	logic        out_valid;
	logic        cfg_restart;

	// only a write that hits a real register restarts the strides and odometer
	assign cfg_restart = cfg_we && (cfg_index inside {REG_RANK, REG_GATHER_AXIS,
		REG_DIM_SIZES_LO, REG_DIM_SIZES_HI});

	// controller: sequencing of stride rebuild, multiply-accumulate and output slot
	gea_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_restart),
		.in_valid  (in_stream.valid),
		.out_ready (out_stream.ready),
		.status    (status),
		.cmd       (cmd),
		.in_ready  (in_ready),
		.out_valid (out_valid)
	);

	// datapath: config registers, odometer, stride table and the shared multiplier
	gea_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.cmd           (cmd),
		.gather_index  (in_stream.gather_index),
		.status        (status),
		.source_offset (out_stream.source_offset),
		.dest_offset   (out_stream.dest_offset),
		.last_element  (out_stream.last_element)
	);

	assign in_stream.ready  = in_ready;
	assign out_stream.valid = out_valid;

	// one item at a time: no second transaction right after an accept
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_stream.valid && in_ready) |=> !in_ready)
		else $error("input accepted twice in a row");

	// a configuration write stalls input while strides are rebuilt
	a_cfg_stall: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_restart |=> !in_ready)
		else $error("input ready right after configuration write");

	// a finished result always appears on the output
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> out_valid)
		else $error("loaded result not presented");

	// a result is only loaded into a free output slot
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (!out_valid || out_stream.ready))
		else $error("output register overwritten while waiting");

endmodule

FILE: verif/tb_gather_elements_address_gen.sv
module tb_gather_elements_address_gen;
	import gea_pkg::*;

	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	// wait after a write that covers the whole stride rebuild
	localparam int SETTLE_CYCLES  = MAX_RANK + 4;
	// idle pause after the last result before the final verdict
	localparam int END_PAUSE      = 2 * MAX_RANK + 8;
	localparam int RANDOM_ITEMS   = 1300;

	// index with no register behind it, writes there must be ignored
	localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 3'd5;

	typedef enum int {
		FLOW_NONE,
		FLOW_SRC,
		FLOW_SNK,
		FLOW_BOTH,
		FLOW_HOLD
	} flow_t;

	typedef struct packed {
		offset_t source_offset;
		offset_t dest_offset;
		logic    last_element;
	} addr_result_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_wdata;

	gea_in_if  in_if ();
	gea_out_if out_if ();

	gather_elements_address_gen u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_stream  (in_if),
		.out_stream (out_if)
	);

	always #10 clk = ~clk;

	// predictor copy of the configuration
	logic [RANK_W-1:0]     tensor_rank;
	logic [AXIS_W-1:0]     axis_sel;
	logic [CFG_DATA_W-1:0] sizes_lo;
	logic [CFG_DATA_W-1:0] sizes_hi;

	// predictor copy of the odometer, strides and element count
	size_t   odometer [MAX_RANK];
	offset_t strides [MAX_RANK];
	offset_t elem_count;

	addr_result_t          expected_addrs [$];
	logic [INDEX_BITS-1:0] index_queue [$];

	flow_t flow_mode = FLOW_NONE;
	int    n_fed = 0;
	int    n_accepted;
	int    n_checked;
	int    n_errors = 0;
	int    quiet_cycles;
	int    hold_count;

	// rank 0 behaves as 1, anything past the maximum as the maximum
	function automatic int active_rank(input logic [RANK_W-1:0] r);
		if (r == '0)
			return 1;
		if (r > MAX_RANK)
			return MAX_RANK;
		return int'(r);
	endfunction

	// size of dimension j from the two packed size words, zero acts as one
	function automatic size_t field_size(input logic [CFG_DATA_W-1:0] lo,
		input logic [CFG_DATA_W-1:0] hi, input int j);
		logic [CFG_DATA_W-1:0] word;
		size_t                 f;
		word = (j < 4) ? lo : hi;
		f = word[(j % 4) * FIELD_W +: SIZE_BITS];
		return (f == '0) ? size_t'(1) : f;
	endfunction

	// row-major strides from the innermost dimension out, odometer back to zero
	function automatic void restart_odometer();
		int r;
		r = active_rank(tensor_rank);
		for (int j = 0; j < MAX_RANK; j++) begin
			odometer[j] = '0;
			strides[j] = '0;
		end
		elem_count = '0;
		strides[r-1] = offset_t'(1);
		for (int j = r - 1; j > 0; j--)
			strides[j-1] = strides[j] * offset_t'(field_size(sizes_lo, sizes_hi, j));
	endfunction

	function automatic void apply_reg_write(input logic [CFG_INDEX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_RANK: begin
				tensor_rank = data[RANK_W-1:0];
			end
			REG_GATHER_AXIS: begin
				axis_sel = data[AXIS_W-1:0];
			end
			REG_DIM_SIZES_LO: begin
				sizes_lo = data;
			end
			REG_DIM_SIZES_HI: begin
				sizes_hi = data;
			end
			default: begin
				return;
			end
		endcase
		restart_odometer();
	endfunction

	// offsets for one gather index, then advance the odometer
	function automatic addr_result_t next_address(input logic [INDEX_BITS-1:0] idx);
		int           r;
		offset_t      src;
		offset_t      c;
		logic         last;
		addr_result_t res;
		r = active_rank(tensor_rank);
		src = '0;
		last = 1'b1;
		for (int j = 0; j < r; j++) begin
			// only the low 32 bits of the index matter once the sum wraps
			c = (j == int'(axis_sel)) ? offset_t'(idx) : offset_t'(odometer[j]);
			src = src + c * strides[j];
			if (odometer[j] != field_size(sizes_lo, sizes_hi, j) - size_t'(1))
				last = 1'b0;
		end
		res.source_offset = src;
		res.dest_offset = elem_count;
		res.last_element = last;
		if (last) begin
			for (int j = 0; j < MAX_RANK; j++)
				odometer[j] = '0;
			elem_count = '0;
		end else begin
			elem_count = elem_count + offset_t'(1);
			// ripple carry from the innermost digit
			for (int j = r; j > 0; j--) begin
				if (int'(odometer[j-1]) + 1 < int'(field_size(sizes_lo, sizes_hi, j - 1))) begin
					odometer[j-1] = odometer[j-1] + size_t'(1);
					break;
				end
				odometer[j-1] = '0;
			end
		end
		return res;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %h got %h", $time, name, want, got);
			n_errors++;
		end
	endtask

	// sender: holds valid until the transaction completes, random gaps per phase
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_if.valid <= 1'b0;
			in_if.gather_index <= '0;
		end else if (!in_if.valid || in_if.ready) begin
			if (index_queue.size() != 0 && $urandom_range(99) >=
				((flow_mode == FLOW_SRC) ? 72 : (flow_mode == FLOW_BOTH) ? 27 : 0)) begin
				in_if.valid <= 1'b1;
				in_if.gather_index <= index_queue.pop_front();
			end else begin
				in_if.valid <= 1'b0;
			end
		end
	end

	// receiver: random stalls, or one long hold-off at the start of a hold phase
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_if.ready <= 1'b0;
			hold_count <= 0;
		end else if (flow_mode == FLOW_HOLD && hold_count < HOLD_CYCLES) begin
			hold_count <= hold_count + 1;
			out_if.ready <= 1'b0;
		end else begin
			if (flow_mode != FLOW_HOLD)
				hold_count <= 0;
			out_if.ready <= ($urandom_range(99) >=
				((flow_mode == FLOW_SNK) ? 72 : (flow_mode == FLOW_BOTH) ? 27 : 0));
		end
	end

	// check the output transaction first, then predict from this edge's input
	always @(posedge clk or negedge arst_n) begin : address_check
		addr_result_t head;
		if (!arst_n) begin
			tensor_rank = RANK_RESET;
			axis_sel = AXIS_RESET;
			sizes_lo = SIZES_RESET;
			sizes_hi = SIZES_RESET;
			restart_odometer();
			expected_addrs.delete();
			n_accepted <= 0;
			n_checked <= 0;
		end else begin
			if (out_if.valid && out_if.ready) begin
				if (expected_addrs.size() == 0) begin
					$display("%0t: unexpected result source %h dest %h last %b", $time,
						out_if.source_offset, out_if.dest_offset, out_if.last_element);
					n_errors++;
				end else begin
					head = expected_addrs.pop_front();
					check_field("source_offset", head.source_offset, out_if.source_offset);
					check_field("dest_offset", head.dest_offset, out_if.dest_offset);
					check_field("last_element", 32'(head.last_element),
						32'(out_if.last_element));
				end
				n_checked <= n_checked + 1;
			end
			if (cfg_we) begin
				apply_reg_write(cfg_index, cfg_wdata);
			end else if (in_if.valid && in_if.ready) begin
				expected_addrs.push_back(next_address(in_if.gather_index));
				n_accepted <= n_accepted + 1;
			end
		end
	end

	// watchdog on cycles with no transaction on either side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	task automatic feed(input logic [INDEX_BITS-1:0] idx);
		index_queue.push_back(idx);
		n_fed++;
	endtask

	// every fed index accepted and every result seen
	task automatic wait_drained();
		do
			@(posedge clk);
		while (n_accepted != n_fed || n_checked != n_fed);
	endtask

	// one write, then let the stride rebuild finish before the next
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input logic [RANK_W-1:0] r, input logic [AXIS_W-1:0] ax,
		input logic [CFG_DATA_W-1:0] lo, input logic [CFG_DATA_W-1:0] hi,
		input logic spare);
		if (spare)
			write_reg(REG_UNMAPPED, {$urandom, $urandom});
		write_reg(REG_RANK, CFG_DATA_W'(r));
		write_reg(REG_GATHER_AXIS, CFG_DATA_W'(ax));
		write_reg(REG_DIM_SIZES_LO, lo);
		write_reg(REG_DIM_SIZES_HI, hi);
	endtask

	// mostly tiny sizes so the odometer wraps often, some zero, some full width
	function automatic logic [CFG_DATA_W-1:0] random_sizes();
		logic [CFG_DATA_W-1:0] w;
		int                    style;
		style = $urandom_range(0, 9);
		case (style)
			7: begin
				w = {$urandom, $urandom};
			end
			8: begin
				w = {4{16'hffff}};
			end
			default: begin
				for (int k = 0; k < 4; k++)
					w[k * FIELD_W +: FIELD_W] = FIELD_W'($urandom_range(0, 4));
			end
		endcase
		return w;
	endfunction

	initial begin : stimulus
		logic [RANK_W-1:0]     r;
		logic [AXIS_W-1:0]     ax;
		logic [CFG_DATA_W-1:0] lo;
		logic [CFG_DATA_W-1:0] hi;
		logic [INDEX_BITS-1:0] idx;
		int                    random_fed;
		int                    phase;
		int                    n_items;
		int                    axis_size;
		int                    pick;

		// known values on every input from time zero
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		in_if.valid = 1'b0;
		in_if.gather_index = '0;
		out_if.ready = 1'b0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings, rank 1 of size 1: every element is the last, source is the index
		@(negedge clk);
		feed(32'h0000_0000);
		feed(32'h7fff_ffff);
		feed(32'h8000_0000);
		feed(32'hffff_ffff);
		feed(32'h0000_0001);
		feed(32'h5555_5555);
		feed(32'haaaa_aaaa);

		// 2 x 3 tensor gathered on the inner axis, runs through one wrap
		wait_drained();
		configure(4'd2, 3'd1, 64'h0000_0000_0003_0002, SIZES_RESET, 1'b1);
		@(negedge clk);
		feed(32'd0);
		feed(32'd1);
		feed(32'd2);
		feed(32'hffff_ffff);
		feed(32'd2);
		feed(32'd0);
		feed(32'd5);

		// a write to an unknown index mid-tensor leaves the odometer running
		wait_drained();
		write_reg(REG_UNMAPPED, {$urandom, $urandom});
		@(negedge clk);
		feed(32'd1);
		feed(32'd2);
		feed(32'd0);

		// rank zero, zero sizes, axis above rank so the index is ignored
		wait_drained();
		configure(4'd0, 3'd3, 64'h0, 64'h0, 1'b0);
		@(negedge clk);
		feed(32'd9);
		feed(32'hffff_fff7);
		feed(32'h8000_0000);

		// rank past the maximum, innermost axis, widest size on dimension 7
		wait_drained();
		configure(4'd15, 3'd7, 64'h0002_0000_0003_0002, 64'hffff_0000_0002_0003, 1'b1);
		@(negedge clk);
		feed(32'd1);
		feed(32'h0000_ffff);
		feed(32'h8000_0000);
		feed(32'h7fff_ffff);

		// random phases, each with its own settings and flow pattern
		random_fed = 0;
		phase = 0;
		while (random_fed < RANDOM_ITEMS) begin
			wait_drained();
			pick = $urandom_range(0, 9);
			if (pick == 0)
				r = RANK_W'($urandom_range(9, 15));
			else if (pick == 1)
				r = '0;
			else
				r = RANK_W'($urandom_range(1, MAX_RANK));
			ax = AXIS_W'($urandom_range(0, MAX_RANK - 1));
			lo = random_sizes();
			hi = random_sizes();
			configure(r, ax, lo, hi, ($urandom_range(0, 3) == 0));
			axis_size = int'(field_size(lo, hi, int'(ax)));
			n_items = $urandom_range(20, 80);

			@(negedge clk);
			flow_mode = flow_t'(phase % 5);
			for (int i = 0; i < n_items; i++) begin
				pick = $urandom_range(0, 99);
				if (pick < 70)
					// in range for the gather axis
					idx = INDEX_BITS'($urandom_range(0, axis_size - 1));
				else if (pick < 85)
					idx = $urandom;
				else if (pick < 92)
					// small negative
					idx = '0 - INDEX_BITS'($urandom_range(1, 4));
				else begin
					case ($urandom_range(0, 3))
						0: idx = 32'h7fff_ffff;
						1: idx = 32'h8000_0000;
						2: idx = INDEX_BITS'(axis_size);
						default: idx = 32'hffff_ffff;
					endcase
				end
				feed(idx);
			end
			random_fed += n_items;
			phase++;
		end

		wait_drained();
		repeat (END_PAUSE) @(posedge clk);
		if (n_errors == 0 && expected_addrs.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

FILE: filelist.f
hw/rtl/gea_pkg.sv
hw/rtl/gea_in_if.sv
hw/rtl/gea_out_if.sv
hw/rtl/gea_ctrl.sv
hw/rtl/gea_datapath.sv
hw/rtl/gather_elements_address_gen.sv
verif/tb_gather_elements_address_gen.sv
